FILE: rtl/rmsenv_pkg.sv
// ----------------------------------------------------------------------------
// rmsenv_pkg
// Shared constants, operation codes and controller/datapath bundles for the
// RMS envelope follower.
// ----------------------------------------------------------------------------
package rmsenv_pkg;

    localparam int LEVEL_FRAC_BITS_DEF = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 88;

    localparam logic [CFG_IDX_W-1:0] CFG_RATE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_MS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE = 2'd3;

    // operations run on the shared divider
    typedef enum logic [2:0] {
        DIV_Q      = 3'd0,
        DIV_RAW    = 3'd1,
        DIV_START  = 3'd2,
        DIV_FRAMES = 3'd3,
        DIV_CLIP   = 3'd4,
        DIV_ADV    = 3'd5
    } div_op_t;

    typedef struct packed {
        logic    accept;
        logic    div_start;
        div_op_t div_op;
        logic    sqrt_start;
        logic    smooth_load;
        logic    clip_drop;
        logic    out_load;
    } rmsenv_cmd_t;

    typedef struct packed {
        logic size_stale;
        logic close_win;
        logic short_clip;
        logic last;
        logic div_done;
        logic sqrt_done;
        logic out_free;
    } rmsenv_stat_t;

endpackage

FILE: rtl/rmsenv_div.sv
// ----------------------------------------------------------------------------
// rmsenv_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rmsenv_div #(
    parameter int DDW = 54,
    parameter int DVW = 21
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [DDW-1:0] dividend,
    input  logic [DVW-1:0] divisor,
    output logic           busy,
    output logic           done,
    output logic [DDW-1:0] quotient
);
    localparam int CW = $clog2(DDW + 1);

    logic           busy_reg;
    logic           done_reg;
    logic [CW-1:0]  cnt_reg;
    logic [DDW-1:0] dd_reg;
    logic [DVW-1:0] rem_reg;
    logic [DVW:0]   sh;
    logic [DVW:0]   diff;
    logic           ge;

    assign sh   = {rem_reg, dd_reg[DDW-1]};
    assign ge   = sh >= {1'b0, divisor};
    assign diff = sh - {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CW'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DDW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dd_reg  <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dd_reg  <= {dd_reg[DDW-2:0], ge};
            rem_reg <= ge ? diff[DVW-1:0] : sh[DVW-1:0];
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = dd_reg;

    a_div_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg) else $error("divider done while busy");

endmodule

FILE: rtl/rmsenv_sqrt.sv
// ----------------------------------------------------------------------------
// rmsenv_sqrt
// Floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module rmsenv_sqrt #(
    parameter int LW = 17
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [2*LW-2:0] radicand,
    output logic            done,
    output logic [LW-1:0]   root
);
    localparam int RW = LW + 2;
    localparam int CW = $clog2(LW + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CW-1:0]   cnt_reg;
    logic [2*LW-1:0] rad_reg;
    logic [RW-1:0]   rem_reg;
    logic [LW-1:0]   root_reg;
    logic [RW-1:0]   rem_sh;
    logic [RW-1:0]   trial;
    logic            ge;

    assign rem_sh = {rem_reg[RW-3:0], rad_reg[2*LW-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CW'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(LW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= {1'b0, radicand};
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[2*LW-3:0], 2'b00};
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[LW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

    a_sqrt_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg) else $error("square root restarted while busy");

endmodule

FILE: rtl/rmsenv_dp.sv
// ----------------------------------------------------------------------------
// rmsenv_dp
// Datapath: configuration registers, window accumulators, shared divider,
// square root unit, level smoothing and the output register.
// ----------------------------------------------------------------------------
module rmsenv_dp #(
    parameter int LEVEL_FRAC_BITS = rmsenv_pkg::LEVEL_FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [rmsenv_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rmsenv_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [rmsenv_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [rmsenv_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                                 m_tlast,
    input  rmsenv_pkg::rmsenv_cmd_t              cmd,
    output rmsenv_pkg::rmsenv_stat_t             stat
);
    import rmsenv_pkg::*;

    localparam int F    = LEVEL_FRAC_BITS;
    localparam int LW   = F + 1;
    localparam int KPOS = (2 * F >= 30) ? 2 * F - 30 : 0;
    localparam int KNEG = (2 * F < 30) ? 30 - 2 * F : 0;
    localparam int DDW  = 52 + KPOS;
    localparam int DVW  = (LW > 21) ? LW : 21;
    localparam int QW   = 2 * F + 1;
    localparam int OSH_R = (F >= 16) ? F - 16 : 0;
    localparam int OSH_L = (F < 16) ? 16 - F : 0;
    localparam int KEPS_I = (((1 << F) / 1000) == 0) ? 1 : (1 << F) / 1000;
    localparam int FPW_SH = 38;
    localparam int SM_SH  = LW + 8;
    localparam logic [LW-1:0]  ONE    = {1'b1, {F{1'b0}}};
    localparam logic [F-1:0]   K032   = F'((64'd32 << F) / 64'd100);
    localparam logic [F-1:0]   KEPS   = F'(KEPS_I);
    localparam logic [39:0]    MAX40  = 40'hFF_FFFF_FFFF;
    localparam logic [DDW-1:0] U32MAX = DDW'(33'h0_FFFF_FFFF);
    // reciprocals: 1/1000 and 58/100, rounded up, exact floor over their ranges
    localparam logic [28:0]      FPW_M = 29'((64'd1 << FPW_SH) / 64'd1000 + 64'd1);
    localparam logic [SM_SH-1:0] SM_M  = SM_SH'((64'd29 << SM_SH) / 64'd50 + 64'd1);

    // configuration
    logic [17:0] rate_reg;
    logic [3:0]  ch_reg;
    logic [9:0]  wms_reg;
    logic [15:0] sil_reg;
    logic [1:0]  stale_cnt_reg;
    logic [17:0] rate_c;
    logic [3:0]  ch_c;
    logic [9:0]  wms_c;

    // window state
    logic [51:0]   sum_reg;
    logic [20:0]   fill_reg;
    logic [39:0]   base_reg;
    logic [39:0]   total_reg;
    logic [LW-1:0] smooth_reg;
    logic          last_reg;
    logic [20:0]   size_reg;
    logic [27:0]   rate_wms_reg;
    logic [55:0]   fpw_prod_reg;

    // intermediate results
    div_op_t       op_reg;
    logic [QW-1:0] q_reg;
    logic [LW-1:0] raw_reg;
    logic [31:0]   start_ms_reg;
    logic [39:0]   frames_reg;
    logic [31:0]   clip_ms_reg;

    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic                 m_last_reg;

    logic [DDW-1:0] dvd;
    logic [DVW-1:0] dvs;
    logic           div_busy;
    logic           div_done;
    logic [DDW-1:0] quo;
    logic           sqrt_done;
    logic [LW-1:0]  rms;

    logic [15:0]         mag;
    logic [30:0]         mag_sq;
    logic [F+15:0]       thr_w;
    logic [F-1:0]        thr;
    logic [F-1:0]        kdiff;
    logic [F-1:0]        denom;
    logic [LW-1:0]       diff;
    logic [QW-1:0]       raw_num;
    logic [27:0]         rate_wms;
    logic [49:0]         base_k;
    logic [49:0]         frames_k;
    logic [LW+SM_SH-1:0] smooth_prod;
    logic [17:0]         fpw;
    logic [21:0]         size_next;
    logic [LW-1:0]       dec;
    logic [LW-1:0]       lvl_next;
    logic [20:0]         adv;
    logic [39:0]         base_next;
    logic [LW+15:0]      open_w;

    assign rate_c = (rate_reg == 18'd0) ? 18'd1 :
                    (rate_reg > 18'd192000) ? 18'd192000 : rate_reg;
    assign ch_c   = (ch_reg == 4'd0) ? 4'd1 : (ch_reg > 4'd8) ? 4'd8 : ch_reg;
    assign wms_c  = (wms_reg == 10'd0) ? 10'd1 :
                    (wms_reg > 10'd1000) ? 10'd1000 : wms_reg;

    assign mag    = s_tdata[15] ? (16'd0 - s_tdata) : s_tdata;
    assign mag_sq = 31'(32'(mag) * 32'(mag));

    // threshold and gain denominator in level units
    assign thr_w = ((F + 16)'(sil_reg) << OSH_R) >> OSH_L;
    assign thr   = thr_w[F-1:0];
    assign kdiff = K032 - thr;
    assign denom = ((K032 > thr) && (kdiff > KEPS)) ? kdiff : KEPS;
    assign diff  = rms - {1'b0, thr};
    assign raw_num = (rms > {1'b0, thr}) ? (QW'(diff) << F) : '0;

    assign rate_wms = 28'(rate_c) * 28'(wms_c);
    assign base_k   = 50'(base_reg) * 50'(1000);
    assign frames_k = 50'(frames_reg) * 50'(1000);

    always_comb begin
        case (cmd.div_op)
            DIV_Q: begin
                dvd = DDW'(sum_reg) << KPOS;
                dvs = DVW'(fill_reg);
            end
            DIV_RAW: begin
                dvd = DDW'(raw_num);
                dvs = DVW'(denom);
            end
            DIV_START: begin
                dvd = DDW'(base_k);
                dvs = DVW'(rate_c);
            end
            DIV_FRAMES: begin
                dvd = DDW'(total_reg);
                dvs = DVW'(ch_c);
            end
            DIV_CLIP: begin
                dvd = DDW'(frames_k);
                dvs = DVW'(rate_c);
            end
            DIV_ADV: begin
                dvd = DDW'(fill_reg);
                dvs = DVW'(ch_c);
            end
            default: begin
                dvd = '0;
                dvs = DVW'(1);
            end
        endcase
    end

    rmsenv_div #(.DDW(DDW), .DVW(DVW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quo)
    );

    rmsenv_sqrt #(.LW(LW)) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.sqrt_start),
        .radicand (q_reg),
        .done     (sqrt_done),
        .root     (rms)
    );

    assign fpw         = (fpw_prod_reg[FPW_SH +: 18] == 18'd0) ? 18'd1 :
                         fpw_prod_reg[FPW_SH +: 18];
    assign size_next   = 22'(fpw) * 22'(ch_c);
    assign smooth_prod = (LW + SM_SH)'(smooth_reg) * (LW + SM_SH)'(SM_M);
    assign dec         = smooth_prod[SM_SH +: LW];
    assign lvl_next    = (raw_reg >= smooth_reg) ? raw_reg :
                         (dec < raw_reg) ? raw_reg : dec;
    assign adv       = quo[20:0];
    assign base_next = (base_reg > (MAX40 - 40'(adv))) ? MAX40 : base_reg + 40'(adv);
    assign open_w    = ((LW + 16)'(smooth_reg) << OSH_L) >> OSH_R;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg      <= 18'd48000;
            ch_reg        <= 4'd1;
            wms_reg       <= 10'd20;
            sil_reg       <= 16'd1311;
            stale_cnt_reg <= 2'd3;
            sum_reg       <= '0;
            fill_reg      <= '0;
            base_reg      <= '0;
            total_reg     <= '0;
            smooth_reg    <= '0;
            last_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            // size pipeline is three stages deep
            if (cfg_wr_en) begin
                stale_cnt_reg <= 2'd3;
                unique case (cfg_index)
                    CFG_RATE:    rate_reg <= cfg_wdata;
                    CFG_CHAN:    ch_reg   <= cfg_wdata[3:0];
                    CFG_WIN_MS:  wms_reg  <= cfg_wdata[9:0];
                    CFG_SILENCE: sil_reg  <= cfg_wdata[15:0];
                endcase
            end else if (stale_cnt_reg != 2'd0) begin
                stale_cnt_reg <= stale_cnt_reg - 2'd1;
            end

            if (cmd.accept) begin
                sum_reg   <= sum_reg + 52'(mag_sq);
                fill_reg  <= fill_reg + 21'd1;
                total_reg <= (total_reg == MAX40) ? MAX40 : total_reg + 40'd1;
                last_reg  <= s_tlast;
            end else if (cmd.clip_drop || (cmd.out_load && last_reg)) begin
                sum_reg    <= '0;
                fill_reg   <= '0;
                base_reg   <= '0;
                total_reg  <= '0;
                smooth_reg <= '0;
            end else if (cmd.out_load) begin
                sum_reg  <= '0;
                fill_reg <= '0;
            end else if (cmd.smooth_load) begin
                smooth_reg <= lvl_next;
            end else if (div_done && op_reg == DIV_ADV) begin
                base_reg <= base_next;
            end

            // a new beat wins over the one being taken
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rate_wms_reg <= rate_wms;
        fpw_prod_reg <= 56'(rate_wms_reg) * 56'(FPW_M);
        size_reg     <= size_next[20:0];
        if (cmd.div_start) begin
            op_reg <= cmd.div_op;
        end
        if (div_done) begin
            case (op_reg)
                DIV_Q:      q_reg        <= QW'(quo >> KNEG);
                DIV_RAW:    raw_reg      <= (quo > DDW'(ONE)) ? ONE : quo[LW-1:0];
                DIV_START:  start_ms_reg <= (quo > U32MAX) ? 32'hFFFF_FFFF : quo[31:0];
                DIV_FRAMES: frames_reg   <= quo[39:0];
                DIV_CLIP:   clip_ms_reg  <= (quo > U32MAX) ? 32'hFFFF_FFFF : quo[31:0];
                default: ;
            endcase
        end
        if (cmd.out_load) begin
            m_data_reg <= {7'd0, (last_reg ? clip_ms_reg : 32'd0), open_w[16:0],
                           start_ms_reg};
            m_last_reg <= last_reg;
        end
    end

    assign stat.size_stale = (stale_cnt_reg != 2'd0);
    assign stat.close_win  = (fill_reg >= size_reg) || last_reg;
    assign stat.short_clip = last_reg && (total_reg < 40'(ch_c));
    assign stat.last       = last_reg;
    assign stat.div_done   = div_done;
    assign stat.sqrt_done  = sqrt_done;
    assign stat.out_free   = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    a_smooth_range: assert property (@(posedge aclk) disable iff (!aresetn)
        smooth_reg <= ONE) else $error("smoothed level above full scale");

    a_div_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !div_busy) else $error("divider started while busy");

endmodule

FILE: rtl/rmsenv_ctrl.sv
// ----------------------------------------------------------------------------
// rmsenv_ctrl
// Sequencer: takes samples, and at window close either drops a too-short clip
// or walks the divide, square root and smoothing steps before loading the result beat.
// ----------------------------------------------------------------------------
module rmsenv_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  rmsenv_pkg::rmsenv_stat_t stat,
    output rmsenv_pkg::rmsenv_cmd_t  cmd
);
    import rmsenv_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_SIZE   = 12'b0000_0000_0010,
        S_CHECK  = 12'b0000_0000_0100,
        S_QDIV   = 12'b0000_0000_1000,
        S_SQRT   = 12'b0000_0001_0000,
        S_RAW    = 12'b0000_0010_0000,
        S_SMOOTH = 12'b0000_0100_0000,
        S_START  = 12'b0000_1000_0000,
        S_FRAMES = 12'b0001_0000_0000,
        S_CLIP   = 12'b0010_0000_0000,
        S_ADV    = 12'b0100_0000_0000,
        S_OUT    = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   launched_reg, launched_next;
    logic   is_div;
    logic   ready;

    assign ready = (state_reg == S_IDLE) && !stat.size_stale;

    always_comb begin
        state_next      = state_reg;
        is_div          = 1'b0;
        cmd.accept      = 1'b0;
        cmd.div_op      = DIV_Q;
        cmd.sqrt_start  = 1'b0;
        cmd.smooth_load = 1'b0;
        cmd.clip_drop   = 1'b0;
        cmd.out_load    = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (stat.size_stale) begin
                    state_next = S_SIZE;
                end else if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_SIZE: begin
                // hold until the window size has settled
                if (!stat.size_stale) state_next = S_IDLE;
            end
            S_CHECK: begin
                if (!stat.close_win) begin
                    state_next = S_IDLE;
                end else if (stat.short_clip) begin
                    cmd.clip_drop = 1'b1;
                    state_next    = S_IDLE;
                end else begin
                    state_next = S_QDIV;
                end
            end
            S_QDIV: begin
                is_div     = 1'b1;
                cmd.div_op = DIV_Q;
                if (stat.div_done) state_next = S_SQRT;
            end
            S_SQRT: begin
                cmd.sqrt_start = !launched_reg;
                if (stat.sqrt_done) state_next = S_RAW;
            end
            S_RAW: begin
                is_div     = 1'b1;
                cmd.div_op = DIV_RAW;
                if (stat.div_done) state_next = S_SMOOTH;
            end
            S_SMOOTH: begin
                cmd.smooth_load = 1'b1;
                state_next      = S_START;
            end
            S_START: begin
                is_div     = 1'b1;
                cmd.div_op = DIV_START;
                if (stat.div_done) state_next = stat.last ? S_FRAMES : S_ADV;
            end
            S_FRAMES: begin
                is_div     = 1'b1;
                cmd.div_op = DIV_FRAMES;
                if (stat.div_done) state_next = S_CLIP;
            end
            S_CLIP: begin
                is_div     = 1'b1;
                cmd.div_op = DIV_CLIP;
                if (stat.div_done) state_next = S_OUT;
            end
            S_ADV: begin
                is_div     = 1'b1;
                cmd.div_op = DIV_ADV;
                if (stat.div_done) state_next = S_OUT;
            end
            S_OUT: begin
                // hold until the output register can take the beat
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        cmd.div_start = is_div && !launched_reg;
        launched_next = (state_next != state_reg) ? 1'b0 :
                        (launched_reg || cmd.div_start || cmd.sqrt_start);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            launched_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            launched_reg <= launched_next;
        end
    end

    assign s_tready = ready;

    a_out_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && stat.out_free) |=> state_reg == S_IDLE)
        else $error("result load did not return to idle");

    a_no_accept_while_stale: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.size_stale |-> !cmd.accept) else $error("sample taken with stale size");

endmodule

FILE: rtl/rms_envelope_follower.sv
// ----------------------------------------------------------------------------
// rms_envelope_follower
// Windowed RMS level with silence gate, gain, instant attack and slow release.
// ----------------------------------------------------------------------------
// A sample that leaves its window open passes the accept and check states.
// A closing sample then runs the divides, square root and smoothing, with
// DDW = 52 + max(0, 2*LEVEL_FRAC_BITS-30) the divider width, plus any wait for
// the output register; the clip's last window takes one divide more.
// The rate is set by the one-bit-per-cycle divider; no new sample is taken until the block is back in idle.
// After reset or a register write a three-stage size pipeline settles
// before the next sample; reset restores registers 48000, 1, 20, 1311.
module rms_envelope_follower #(
    parameter int LEVEL_FRAC_BITS = rmsenv_pkg::LEVEL_FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [rmsenv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rmsenv_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rmsenv_pkg::S_TDATA_W-1:0]  s_tdata,   // [15:0] pcm_sample
    input  logic                              s_tlast,   // clip_end
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rmsenv_pkg::M_TDATA_W-1:0]  m_tdata,   // [31:0] start_ms,
                                                         // [48:32] openness,
                                                         // [80:49] clip_ms
    output logic                              m_tlast    // final_res
);
    import rmsenv_pkg::*;

    rmsenv_cmd_t  cmd;
    rmsenv_stat_t stat;

    rmsenv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rmsenv_dp #(.LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

FILE: tb/rms_envelope_follower_tb.sv
// ----------------------------------------------------------------------------
// rms_envelope_follower_tb
// Self-checking bench for the RMS envelope follower. PCM beats are driven
// from a queue of pending samples and scored against an in-bench model of the
// window sums, RMS level, silence gate, gain and attack/release smoothing.
// Register settings are changed only between phases, once the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rms_envelope_follower_tb;
    import rmsenv_pkg::*;

    localparam int  CLK_PERIOD   = 12;
    localparam int  DRAIN_CYCLES = 500;
    localparam int  HOLD_CYCLES  = 3000;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam logic [63:0] SAT40 = (64'd1 << 40) - 1;

    typedef struct {
        logic [15:0] pcm;
        logic        clip_end;
    } pcm_beat_t;

    typedef struct {
        logic [31:0] start_ms;
        logic [16:0] openness;
        logic [31:0] clip_ms;
        logic        final_res;
    } envelope_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;

    pcm_beat_t pending_beats[$];
    envelope_t expected_env[$];

    // model copy of the registers and running state
    logic [63:0] rate_reg, chan_reg, win_reg, silence_reg;
    logic [63:0] sq_sum, win_fill, base_frame, sample_total, smooth_lvl;

    int     mismatches;
    longint cycles;
    logic   beat_taken;
    logic   no_idle;
    logic   stall_req;
    logic   stall_done;
    int     hold_left;

    rms_envelope_follower uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    function automatic logic [63:0] clamp64(logic [63:0] v, logic [63:0] lo, logic [63:0] hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= root + bitv) begin
                x = x - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [63:0] frames_to_ms(logic [63:0] frames, logic [63:0] rate);
        logic [63:0] v;
        v = (frames * 64'd1000) / rate;
        return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
    endfunction

    // gated, scaled level of one window, 16 fraction bits
    function automatic logic [63:0] gated_level(logic [63:0] sum, logic [63:0] n,
                                                logic [63:0] thr);
        logic [63:0] mean_q, rms, k032, keps, denom, lvl;
        mean_q = ((sum / n) << 2) + (((sum % n) << 2) / n);
        rms = int_sqrt(mean_q);
        if (rms <= thr) return 0;
        k032 = (64'd32 << 16) / 64'd100;
        keps = 64'd65536 / 64'd1000;
        denom = (k032 > thr && k032 - thr > keps) ? (k032 - thr) : keps;
        lvl = ((rms - thr) << 16) / denom;
        return (lvl > 64'd65536) ? 64'd65536 : lvl;
    endfunction

    function automatic void clear_clip();
        sq_sum = 0;
        win_fill = 0;
        base_frame = 0;
        sample_total = 0;
        smooth_lvl = 0;
    endfunction

    // advance the envelope state by one sample; returns 1 when a window closes with a result
    function automatic bit envelope_step(logic [15:0] pcm, logic last, output envelope_t env);
        logic [63:0] rate, ch, wms, fpw, win_size, mag, raw, lvl, adv;
        rate = clamp64(rate_reg, 64'd1, 64'd192000);
        ch   = clamp64(chan_reg, 64'd1, 64'd8);
        wms  = clamp64(win_reg, 64'd1, 64'd1000);
        fpw  = (rate * wms) / 64'd1000;
        if (fpw == 0) fpw = 1;
        win_size = fpw * ch;
        mag = {48'd0, pcm};
        if (pcm[15]) mag = 64'h10000 - mag;
        sq_sum = sq_sum + mag * mag;
        win_fill = win_fill + 1;
        if (sample_total < SAT40) sample_total = sample_total + 1;
        env = '{default: '0};
        if (win_fill < win_size && !last) return 0;
        if (last && sample_total < ch) begin
            clear_clip();
            return 0;
        end
        raw = gated_level(sq_sum, win_fill, silence_reg);
        if (raw >= smooth_lvl) begin
            lvl = raw;
        end else begin
            lvl = (smooth_lvl * 64'd58) / 64'd100;
            if (lvl < raw) lvl = raw;
        end
        smooth_lvl = lvl;
        env.start_ms  = 32'(frames_to_ms(base_frame, rate));
        env.openness  = lvl[16:0];
        env.clip_ms   = last ? 32'(frames_to_ms(sample_total / ch, rate)) : 32'd0;
        env.final_res = last;
        if (last) begin
            clear_clip();
        end else begin
            adv = win_fill / ch;
            base_frame = (base_frame > SAT40 - adv) ? SAT40 : base_frame + adv;
            sq_sum = 0;
            win_fill = 0;
        end
        return 1;
    endfunction

    // score results and predict accepted beats
    always @(posedge aclk) begin
        envelope_t env;
        envelope_t want;
        logic      fired;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL rms_envelope_follower");
            $finish;
        end else begin
            beat_taken <= aresetn && s_tvalid && s_tready;
            if (aresetn && s_tvalid && s_tready) begin
                fired = envelope_step(s_tdata, s_tlast, env);
                if (fired) expected_env.insert(expected_env.size(), env);
            end
            if (aresetn && m_tvalid && m_tready) begin
                if (expected_env.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected result beat: %h last %b", m_tdata, m_tlast);
                end else begin
                    want = expected_env.pop_front();
                    if (m_tdata[31:0] !== want.start_ms || m_tdata[48:32] !== want.openness ||
                        m_tdata[80:49] !== want.clip_ms || m_tlast !== want.final_res) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display({"mismatch: exp start %0d open %0d clip %0d last %b,",
                                      " got start %0d open %0d clip %0d last %b"},
                                     want.start_ms, want.openness, want.clip_ms,
                                     want.final_res, m_tdata[31:0], m_tdata[48:32],
                                     m_tdata[80:49], m_tlast);
                    end
                end
            end
        end
    end

    // sample driver: hold a beat until taken, then maybe idle
    always @(negedge aclk) begin
        pcm_beat_t nb;
        if (aresetn && (!s_tvalid || beat_taken)) begin
            if (pending_beats.size() != 0 && (no_idle || $urandom_range(99) >= 10)) begin
                nb = pending_beats.pop_front();
                s_tdata  <= nb.pcm;
                s_tlast  <= nb.clip_end;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off on request
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (stall_req && !stall_done) begin
            m_tready   <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            stall_done <= 1'b1;
        end else begin
            m_tready <= no_idle || ($urandom_range(99) >= 10);
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            CFG_RATE:    rate_reg    = {46'd0, val};
            CFG_CHAN:    chan_reg    = {60'd0, val[3:0]};
            CFG_WIN_MS:  win_reg     = {54'd0, val[9:0]};
            CFG_SILENCE: silence_reg = {48'd0, val[15:0]};
            default: ;
        endcase
    endtask

    task automatic set_regs(int rate, int ch, int wms, int sil);
        write_reg(CFG_RATE, rate[17:0]);
        write_reg(CFG_CHAN, ch[17:0]);
        write_reg(CFG_WIN_MS, wms[17:0]);
        write_reg(CFG_SILENCE, sil[17:0]);
    endtask

    task automatic add_beat(logic [15:0] pcm, logic last);
        pcm_beat_t b;
        b.pcm = pcm;
        b.clip_end = last;
        pending_beats.insert(pending_beats.size(), b);
    endtask

    function automatic logic [15:0] random_pcm();
        int pick;
        int amp;
        pick = $urandom_range(99);
        if (pick < 45) return 16'($urandom_range(65535));
        if (pick < 60) return ($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000;
        if (pick < 85) begin
            amp = $urandom_range(1000);
            amp = amp - 500;
            return amp[15:0];
        end
        return 16'd0;
    endfunction

    task automatic add_random(int count);
        repeat (count) add_beat(random_pcm(), $urandom_range(39) == 0);
    endtask

    task automatic drain();
        wait (pending_beats.size() == 0 && !s_tvalid && expected_env.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    initial begin
        aresetn    = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = CFG_RATE;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        m_tready   = 1'b0;
        mismatches = 0;
        cycles     = 0;
        beat_taken = 1'b0;
        no_idle    = 1'b0;
        stall_req  = 1'b0;
        stall_done = 1'b0;
        hold_left  = 0;
        rate_reg    = 48000;
        chan_reg    = 1;
        win_reg     = 20;
        silence_reg = 1311;
        clear_clip();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset settings: one partial window ended by clip end
        add_beat(16'h7FFF, 1'b0);
        add_beat(16'h8000, 1'b0);
        add_beat(16'h0001, 1'b1);
        drain();

        // one-sample windows: extremes and release after a loud window
        set_regs(1000, 1, 1, 0);
        add_beat(16'h8000, 1'b0);
        add_beat(16'h7FFF, 1'b0);
        add_beat(16'h0000, 1'b0);
        add_beat(16'hFFFF, 1'b0);
        add_beat(16'h0001, 1'b0);
        add_beat(16'h0000, 1'b1);
        add_beat(16'h1234, 1'b1);
        drain();

        // eight channels: clip shorter than a frame gives nothing
        set_regs(1000, 8, 1, 1311);
        add_beat(16'h7FFF, 1'b0);
        add_beat(16'h8000, 1'b0);
        add_beat(16'h4000, 1'b1);
        repeat (8) add_beat(16'hC000, 1'b0);
        repeat (3) add_beat(16'h0100, 1'b0);
        add_beat(16'h0100, 1'b1);
        drain();

        // below-range registers clamp up; silence gate at full scale
        set_regs(0, 0, 0, 65535);
        add_beat(16'h8000, 1'b0);
        add_beat(16'h7FFF, 1'b1);
        drain();

        // above-range registers clamp down: huge window, partial only
        set_regs(262143, 15, 1023, 20000);
        add_random(30);
        add_beat(16'h8000, 1'b1);
        drain();

        // random part with the long receiver hold-off
        set_regs(3000, 2, 1, 500);
        stall_req = 1'b1;
        add_random(300);
        add_beat(random_pcm(), 1'b1);
        drain();

        // random part with no idling on either side
        set_regs(2000, 3, 2, 2000);
        no_idle = 1'b1;
        add_random(250);
        add_beat(random_pcm(), 1'b1);
        drain();
        no_idle = 1'b0;

        set_regs(1, 1, 1000, 0);
        add_random(250);
        add_beat(random_pcm(), 1'b1);
        drain();

        if (mismatches == 0 && expected_env.size() == 0) begin
            $display("PASS rms_envelope_follower");
        end else begin
            $display("FAIL rms_envelope_follower");
        end
        $finish;
    end

endmodule
